// ----- src/secant_quadratic_root_finder_defines.svh -----
// assertion macros used by the root finder top level
`ifndef SECANT_QUADRATIC_ROOT_FINDER_DEFINES_SVH
`define SECANT_QUADRATIC_ROOT_FINDER_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define SQRF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define SQRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/sqrf_pkg.sv -----
package sqrf_pkg;

  localparam int WORD_BITS      = 32;
  localparam int FRACTION_BITS  = 16;
  localparam int TOL_BITS       = 16;
  localparam int LIMIT_BITS     = 8;
  localparam int STEP_BITS      = 8;
  localparam int STATUS_BITS    = 2;
  localparam int REG_INDEX_BITS = 3;
  localparam int APB_ADDR_BITS  = REG_INDEX_BITS + 2;
  localparam int APB_DATA_BITS  = 32;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WORD_BITS-1:0]        mag_t;
  typedef logic [2*WORD_BITS-1:0]      prod_t;

  // saturation limits as magnitudes
  localparam mag_t POS_MAG = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam mag_t NEG_MAG = {1'b1, {(WORD_BITS-1){1'b0}}};

  // status codes
  localparam logic [STATUS_BITS-1:0] STATUS_CONVERGED = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_ZERO_DEN  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_LIMIT     = 2'd2;
  localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW  = 2'd3;

  // register indexes
  localparam logic [REG_INDEX_BITS-1:0] REG_COEF_SQUARE     = 3'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_COEF_LINEAR     = 3'd1;
  localparam logic [REG_INDEX_BITS-1:0] REG_COEF_CONSTANT   = 3'd2;
  localparam logic [REG_INDEX_BITS-1:0] REG_REL_TOLERANCE   = 3'd3;
  localparam logic [REG_INDEX_BITS-1:0] REG_ITERATION_LIMIT = 3'd4;

  // register reset values
  localparam word_t COEF_SQUARE_RST   = WORD_BITS'(-(longint'(1) << FRACTION_BITS));
  localparam word_t COEF_LINEAR_RST   = WORD_BITS'(longint'(10) << FRACTION_BITS);
  localparam word_t COEF_CONSTANT_RST = WORD_BITS'(-(longint'(20) << FRACTION_BITS));
  localparam logic [TOL_BITS-1:0]   REL_TOLERANCE_RST   = 16'd66;
  localparam logic [LIMIT_BITS-1:0] ITERATION_LIMIT_RST = 8'd64;

  typedef struct packed {
    word_t first_guess;
    word_t second_guess;
  } in_t;

  typedef struct packed {
    word_t                  root;
    logic [STEP_BITS-1:0]   steps_taken;
    logic [STATUS_BITS-1:0] status;
  } out_t;

  typedef struct packed {
    word_t                 coef_square;
    word_t                 coef_linear;
    word_t                 coef_constant;
    logic [TOL_BITS-1:0]   rel_tolerance;
    logic [LIMIT_BITS-1:0] iteration_limit;
  } cfg_t;

  typedef struct packed {
    logic issue;
    mag_t op_a;
    mag_t op_b;
    logic neg;
  } mul_req_t;

  typedef struct packed {
    prod_t prod;
    word_t fx;
    logic  fx_sat;
  } mul_res_t;

  typedef struct packed {
    prod_t quot;
    logic  done;
  } div_res_t;

endpackage

// ----- src/sqrf_regs.sv -----
module sqrf_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sqrf_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [sqrf_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [sqrf_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready,
  output sqrf_pkg::cfg_t                     cfg
);
  import sqrf_pkg::*;

  logic [REG_INDEX_BITS-1:0] idx;
  logic                      wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[REG_INDEX_BITS+1:2];
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_square     <= COEF_SQUARE_RST;
      cfg.coef_linear     <= COEF_LINEAR_RST;
      cfg.coef_constant   <= COEF_CONSTANT_RST;
      cfg.rel_tolerance   <= REL_TOLERANCE_RST;
      cfg.iteration_limit <= ITERATION_LIMIT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_COEF_SQUARE:     cfg.coef_square     <= pwdata[WORD_BITS-1:0];
        REG_COEF_LINEAR:     cfg.coef_linear     <= pwdata[WORD_BITS-1:0];
        REG_COEF_CONSTANT:   cfg.coef_constant   <= pwdata[WORD_BITS-1:0];
        REG_REL_TOLERANCE:   cfg.rel_tolerance   <= pwdata[TOL_BITS-1:0];
        REG_ITERATION_LIMIT: cfg.iteration_limit <= pwdata[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_COEF_SQUARE:     prdata = APB_DATA_BITS'(cfg.coef_square);
      REG_COEF_LINEAR:     prdata = APB_DATA_BITS'(cfg.coef_linear);
      REG_COEF_CONSTANT:   prdata = APB_DATA_BITS'(cfg.coef_constant);
      REG_REL_TOLERANCE:   prdata = APB_DATA_BITS'(cfg.rel_tolerance);
      REG_ITERATION_LIMIT: prdata = APB_DATA_BITS'(cfg.iteration_limit);
      default:             prdata = '0;
    endcase
  end

endmodule

// ----- src/sqrf_mul.sv -----
module sqrf_mul (
  input  logic               clk,
  input  sqrf_pkg::mul_req_t req,
  output sqrf_pkg::mul_res_t res
);
  import sqrf_pkg::*;

  localparam int SH_BITS = 2*WORD_BITS - FRACTION_BITS;

  prod_t              prod;
  logic               neg;
  logic [SH_BITS-1:0] shifted;
  mag_t               lim;
  logic               sat;
  mag_t               mag;
  word_t              fx_next;
  word_t              fx;
  logic               fx_sat;

  // stage one: raw magnitude product, held until the next issue
  always_ff @(posedge clk) begin
    if (req.issue) begin
      prod <= prod_t'(req.op_a) * prod_t'(req.op_b);
      neg  <= req.neg;
    end
  end

  // stage two: drop fraction bits, saturate, apply sign
  always_comb begin
    shifted = prod[2*WORD_BITS-1:FRACTION_BITS];
    lim     = neg ? NEG_MAG : POS_MAG;
    sat     = shifted > SH_BITS'(lim);
    mag     = sat ? lim : shifted[WORD_BITS-1:0];
    fx_next = neg ? word_t'(mag_t'(0) - mag) : word_t'(mag);
  end

  always_ff @(posedge clk) begin
    fx     <= fx_next;
    fx_sat <= sat;
  end

  assign res = {prod, fx, fx_sat};

endmodule

// ----- src/sqrf_div.sv -----
module sqrf_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  sqrf_pkg::prod_t    numer,
  input  sqrf_pkg::mag_t     denom,
  output sqrf_pkg::div_res_t res
);
  import sqrf_pkg::*;

  localparam int QBITS    = 2*WORD_BITS;
  localparam int CNT_BITS = $clog2(QBITS + 1);

  prod_t               nq;
  mag_t                rem;
  mag_t                dsr;
  logic [CNT_BITS-1:0] cnt;
  logic                done;
  logic [WORD_BITS:0]  rem_sh;
  logic [WORD_BITS:0]  rem_sub;
  logic                ge;

  // restoring division, one quotient bit per cycle; dividend bits shift
  // out of the top of nq while quotient bits shift in at the bottom
  always_comb begin
    rem_sh  = {rem, nq[QBITS-1]};
    rem_sub = rem_sh - {1'b0, dsr};
    ge      = rem_sh >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_BITS'(1));
      if (start) begin
        nq  <= numer;
        rem <= '0;
        dsr <= denom;
        cnt <= CNT_BITS'(QBITS);
      end else if (cnt != '0) begin
        nq  <= {nq[QBITS-2:0], ge};
        rem <= ge ? rem_sub[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign res = {nq, done};

endmodule

// ----- src/secant_quadratic_root_finder.sv -----
// each secant step runs the polynomial on both points, then the divider, which yields one
//   quotient bit per cycle; a step that ends on a zero denominator stops before the divider
// throughput: one item at a time; busy is high from the start transfer to the result strobe
// the result shows for exactly one cycle with done; the receiver cannot stall
// reset (synchronous, rst high) idles the sequencer and restores the configuration registers
`include "secant_quadratic_root_finder_defines.svh"

module secant_quadratic_root_finder (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  sqrf_pkg::in_t                      request,
  output logic                               busy,
  output logic                               done,
  output sqrf_pkg::out_t                     result,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sqrf_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [sqrf_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [sqrf_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready
);
  import sqrf_pkg::*;

  localparam int W        = WORD_BITS;
  localparam int CMP_BITS = W + 1 + TOL_BITS;

  // sequencer states
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_SQ_I   = 5'd1;   // issue x*x
  localparam logic [4:0] S_SQ_W   = 5'd2;
  localparam logic [4:0] S_SQ_D   = 5'd3;   // latch x^2
  localparam logic [4:0] S_A_I    = 5'd4;   // issue a*x^2
  localparam logic [4:0] S_A_W    = 5'd5;   // issue b*x behind it
  localparam logic [4:0] S_A_D    = 5'd6;   // latch a*x^2
  localparam logic [4:0] S_B_D    = 5'd7;   // add b*x, clamp
  localparam logic [4:0] S_C      = 5'd8;   // add c, clamp, store f
  localparam logic [4:0] S_DEN    = 5'd9;   // denominator and point difference
  localparam logic [4:0] S_NUM_I  = 5'd10;  // issue f(xa)*(xb-xa)
  localparam logic [4:0] S_DIV_GO = 5'd11;
  localparam logic [4:0] S_DIV_W  = 5'd12;
  localparam logic [4:0] S_QSAT   = 5'd13;  // saturate quotient, apply sign
  localparam logic [4:0] S_NEXT   = 5'd14;  // new point, issue tol*|xa|
  localparam logic [4:0] S_CHG    = 5'd15;  // |xa - new|
  localparam logic [4:0] S_CMP    = 5'd16;  // stopping test, shift points

  localparam word_t POS_WORD = word_t'(POS_MAG);
  localparam word_t NEG_WORD = word_t'(NEG_MAG);

  cfg_t     cfg;
  mul_req_t mreq;
  mul_res_t mres;
  div_res_t dres;
  logic     div_start;
  mag_t     div_den;

  logic [4:0]           state;
  logic                 sel;      // which point the polynomial pass works on
  word_t                xa;
  word_t                xb;
  word_t                fa;
  word_t                fb;
  word_t                sq;
  word_t                p1;
  word_t                t_sum;
  word_t                den;
  word_t                diff;
  word_t                q;
  word_t                xn;
  logic [W:0]           chg;
  logic [STEP_BITS-1:0] steps;
  logic                 sat_flag;

  word_t                x_sel;
  logic [W:0]           t_full;
  logic [W:0]           f_full;
  logic [W:0]           den_full;
  logic [W:0]           diff_full;
  logic [W:0]           xn_full;
  logic [W:0]           chg_full;
  logic [W:0]           chg_mag;
  word_t                den_word;
  logic                 den_zero;
  logic                 q_neg;
  mag_t                 q_lim;
  logic                 q_sat;
  mag_t                 q_mag;
  word_t                q_word;
  logic [CMP_BITS-1:0]  change_ext;
  logic [CMP_BITS-1:0]  bound_ext;
  logic                 moving;
  logic [STEP_BITS-1:0] steps_inc;

  function automatic mag_t mag_of(input word_t v);
    return v[W-1] ? mag_t'(0) - mag_t'(v) : mag_t'(v);
  endfunction

  // saturate a one-bit-grown sum back to the word
  function automatic word_t clamp_word(input logic [W:0] v);
    if (v[W] != v[W-1]) begin
      return v[W] ? NEG_WORD : POS_WORD;
    end
    return word_t'(v[W-1:0]);
  endfunction

  function automatic logic clamp_hit(input logic [W:0] v);
    return v[W] ^ v[W-1];
  endfunction

  sqrf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // shared multiplier: the raw product is registered on issue, and the saturated
  // fixed-point product is registered in the cycle after it
  sqrf_mul u_mul (
    .clk (clk),
    .req (mreq),
    .res (mres)
  );

  sqrf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (mres.prod),
    .denom (div_den),
    .res   (dres)
  );

  assign busy      = (state != S_IDLE);
  assign div_start = (state == S_DIV_GO);
  assign div_den   = mag_of(den);

  // multiplier operand selection per sequencer step
  always_comb begin
    mreq = '0;
    unique case (state)
      S_SQ_I: begin
        mreq.issue = 1'b1;
        mreq.op_a  = mag_of(x_sel);
        mreq.op_b  = mag_of(x_sel);
      end
      S_A_I: begin
        mreq.issue = 1'b1;
        mreq.op_a  = mag_of(cfg.coef_square);
        mreq.op_b  = mag_of(sq);
        mreq.neg   = cfg.coef_square[W-1] ^ sq[W-1];
      end
      S_A_W: begin
        mreq.issue = 1'b1;
        mreq.op_a  = mag_of(cfg.coef_linear);
        mreq.op_b  = mag_of(x_sel);
        mreq.neg   = cfg.coef_linear[W-1] ^ x_sel[W-1];
      end
      S_NUM_I: begin
        // exact numerator magnitude for the divider
        mreq.issue = 1'b1;
        mreq.op_a  = mag_of(fa);
        mreq.op_b  = mag_of(diff);
      end
      S_NEXT: begin
        // tolerance bound tol*|xa|, held in the product register
        mreq.issue = 1'b1;
        mreq.op_a  = mag_t'(cfg.rel_tolerance);
        mreq.op_b  = mag_of(xa);
      end
      default: ;
    endcase
  end

  always_comb begin
    x_sel     = sel ? xb : xa;
    t_full    = {p1[W-1], p1} + {mres.fx[W-1], mres.fx};
    f_full    = {t_sum[W-1], t_sum} + {cfg.coef_constant[W-1], cfg.coef_constant};
    den_full  = {fb[W-1], fb} - {fa[W-1], fa};
    diff_full = {xb[W-1], xb} - {xa[W-1], xa};
    xn_full   = {xa[W-1], xa} - {q[W-1], q};
    chg_full  = {xa[W-1], xa} - {xn[W-1], xn};
    chg_mag   = chg_full[W] ? {(W+1){1'b0}} - chg_full : chg_full;
    den_word  = clamp_word(den_full);
    den_zero  = (den_word == '0);
    // quotient sign from the three operand signs
    q_neg     = fa[W-1] ^ diff[W-1] ^ den[W-1];
    q_lim     = q_neg ? NEG_MAG : POS_MAG;
    q_sat     = dres.quot > prod_t'(q_lim);
    q_mag     = q_sat ? q_lim : dres.quot[W-1:0];
    q_word    = q_neg ? word_t'(mag_t'(0) - q_mag) : word_t'(q_mag);
    // relative test without division: |xa-new|*2^16 > tol*|xa|
    change_ext = {chg, {TOL_BITS{1'b0}}};
    bound_ext  = CMP_BITS'(mres.prod[W+TOL_BITS-1:0]);
    moving     = change_ext > bound_ext;
    steps_inc  = steps + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            xa       <= request.first_guess;
            xb       <= request.second_guess;
            sel      <= 1'b0;
            steps    <= '0;
            sat_flag <= 1'b0;
            state    <= S_SQ_I;
          end
        end
        S_SQ_I: state <= S_SQ_W;
        S_SQ_W: state <= S_SQ_D;
        S_SQ_D: begin
          sq       <= mres.fx;
          sat_flag <= sat_flag | mres.fx_sat;
          state    <= S_A_I;
        end
        S_A_I: state <= S_A_W;
        S_A_W: state <= S_A_D;
        S_A_D: begin
          p1       <= mres.fx;
          sat_flag <= sat_flag | mres.fx_sat;
          state    <= S_B_D;
        end
        S_B_D: begin
          t_sum    <= clamp_word(t_full);
          sat_flag <= sat_flag | mres.fx_sat | clamp_hit(t_full);
          state    <= S_C;
        end
        S_C: begin
          sat_flag <= sat_flag | clamp_hit(f_full);
          if (!sel) begin
            fa    <= clamp_word(f_full);
            sel   <= 1'b1;
            state <= S_SQ_I;
          end else begin
            fb    <= clamp_word(f_full);
            state <= S_DEN;
          end
        end
        S_DEN: begin
          steps <= steps_inc;
          den   <= den_word;
          diff  <= clamp_word(diff_full);
          if (den_zero) begin
            // flat secant: stop on the latest point
            result.root        <= xb;
            result.steps_taken <= steps_inc;
            result.status      <= STATUS_ZERO_DEN;
            done               <= 1'b1;
            state              <= S_IDLE;
          end else begin
            sat_flag <= sat_flag | clamp_hit(den_full) | clamp_hit(diff_full);
            state    <= S_NUM_I;
          end
        end
        S_NUM_I:  state <= S_DIV_GO;
        S_DIV_GO: state <= S_DIV_W;
        S_DIV_W: begin
          if (dres.done) begin
            state <= S_QSAT;
          end
        end
        S_QSAT: begin
          q        <= q_word;
          sat_flag <= sat_flag | q_sat;
          state    <= S_NEXT;
        end
        S_NEXT: begin
          xn       <= clamp_word(xn_full);
          sat_flag <= sat_flag | clamp_hit(xn_full);
          state    <= S_CHG;
        end
        S_CHG: begin
          chg   <= chg_mag;
          state <= S_CMP;
        end
        S_CMP: begin
          xa <= xb;
          xb <= xn;
          if (!moving) begin
            result.root        <= xn;
            result.steps_taken <= steps;
            result.status      <= sat_flag ? STATUS_OVERFLOW : STATUS_CONVERGED;
            done               <= 1'b1;
            state              <= S_IDLE;
          end else if (steps >= cfg.iteration_limit) begin
            // a limit of zero stops after the first step as well
            result.root        <= xn;
            result.steps_taken <= steps;
            result.status      <= sat_flag ? STATUS_OVERFLOW : STATUS_LIMIT;
            done               <= 1'b1;
            state              <= S_IDLE;
          end else begin
            sel   <= 1'b0;
            state <= S_SQ_I;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SQRF_ASSERT_SAME(a_done_idle, done, !busy, "result strobe while still busy")
  `SQRF_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
  `SQRF_ASSERT_NEXT(a_start_busy, start && !busy, busy, "start transfer did not begin a run")
  `SQRF_ASSERT_SAME(a_steps_nonzero, done, result.steps_taken != '0, "result with no step")

endmodule
